/* design/sct_pkg.sv */
// ----------------------------------------------------------------------------
// sct_pkg - source character tokenizer shared definitions
// Token kind codes, the result record and the keyword matcher.
// ----------------------------------------------------------------------------
package sct_pkg;

   localparam int KIND_W = 6;
   localparam int CHAR_W = 8;
   localparam int WORD_DEPTH = 6;
   localparam int KW_COUNT = 9;

   // token kinds
   localparam logic [KIND_W-1:0] KIND_EOF        = 6'd0;
   localparam logic [KIND_W-1:0] KIND_STRING     = 6'd1;
   localparam logic [KIND_W-1:0] KIND_IDENT      = 6'd2;
   localparam logic [KIND_W-1:0] KIND_NUMBER     = 6'd3;
   localparam logic [KIND_W-1:0] KIND_KW_FIRST   = 6'd4;
   localparam logic [KIND_W-1:0] KIND_LPAREN     = 6'd13;
   localparam logic [KIND_W-1:0] KIND_RPAREN     = 6'd14;
   localparam logic [KIND_W-1:0] KIND_LBRACE     = 6'd15;
   localparam logic [KIND_W-1:0] KIND_RBRACE     = 6'd16;
   localparam logic [KIND_W-1:0] KIND_COLON      = 6'd17;
   localparam logic [KIND_W-1:0] KIND_SEMI       = 6'd18;
   localparam logic [KIND_W-1:0] KIND_COMMA      = 6'd19;
   localparam logic [KIND_W-1:0] KIND_ASSIGN     = 6'd20;
   localparam logic [KIND_W-1:0] KIND_EQ         = 6'd21;
   localparam logic [KIND_W-1:0] KIND_PLUS       = 6'd22;
   localparam logic [KIND_W-1:0] KIND_INC        = 6'd23;
   localparam logic [KIND_W-1:0] KIND_PLUS_EQ    = 6'd24;
   localparam logic [KIND_W-1:0] KIND_MINUS      = 6'd25;
   localparam logic [KIND_W-1:0] KIND_DEC        = 6'd26;
   localparam logic [KIND_W-1:0] KIND_MINUS_EQ   = 6'd27;
   localparam logic [KIND_W-1:0] KIND_STAR       = 6'd28;
   localparam logic [KIND_W-1:0] KIND_STAR_EQ    = 6'd29;
   localparam logic [KIND_W-1:0] KIND_SLASH      = 6'd30;
   localparam logic [KIND_W-1:0] KIND_PERCENT    = 6'd31;
   localparam logic [KIND_W-1:0] KIND_LT         = 6'd32;
   localparam logic [KIND_W-1:0] KIND_LE         = 6'd33;
   localparam logic [KIND_W-1:0] KIND_GT         = 6'd34;
   localparam logic [KIND_W-1:0] KIND_GE         = 6'd35;
   localparam logic [KIND_W-1:0] KIND_NOT        = 6'd36;
   localparam logic [KIND_W-1:0] KIND_NE         = 6'd37;
   localparam logic [KIND_W-1:0] KIND_AND        = 6'd38;
   localparam logic [KIND_W-1:0] KIND_OR         = 6'd39;
   localparam logic [KIND_W-1:0] KIND_UNKNOWN    = 6'd40;

   // input op codes
   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_END  = 1'b1;

   // keyword spellings, first character at index 0
   localparam logic [CHAR_W-1:0] KW_CHARS [KW_COUNT][WORD_DEPTH] = '{
      '{"f", "u", "n", "c", 8'h00, 8'h00},
      '{"p", "r", "i", "n", "t", 8'h00},
      '{"r", "e", "t", "u", "r", "n"},
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "l", "s", "e", 8'h00, 8'h00},
      '{"w", "h", "i", "l", "e", 8'h00},
      '{"v", "a", "r", 8'h00, 8'h00, 8'h00},
      '{"t", "r", "u", "e", 8'h00, 8'h00},
      '{"f", "a", "l", "s", "e", 8'h00}
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd4, 3'd5, 3'd6, 3'd2, 3'd4, 3'd5, 3'd3,
                                               3'd4, 3'd5};

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              has_text;
      logic [CHAR_W-1:0] text;
      logic              token_done;
      logic              unterminated;
      logic              last;
   } rsp_type;

   function automatic rsp_type make_rsp(input logic [KIND_W-1:0] kind,
                                        input logic has_text,
                                        input logic [CHAR_W-1:0] text,
                                        input logic token_done,
                                        input logic unterminated);
      rsp_type r;
      r.kind         = kind;
      r.has_text     = has_text;
      r.text         = text;
      r.token_done   = token_done;
      r.unterminated = unterminated;
      r.last         = 1'b0;
      return r;
   endfunction

   // Only bytes below len take part, so unwritten buffer entries never matter.
   function automatic logic [KIND_W-1:0] keyword_kind(input logic [WORD_DEPTH-1:0][CHAR_W-1:0] word,
                                                      input logic [2:0] len);
      logic [KIND_W-1:0] kind;
      logic              hit;
      kind = KIND_IDENT;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         hit = (len == KW_LEN[k]);
         for (int b = 0; b < WORD_DEPTH; b++) begin
            if (3'(b) < KW_LEN[k] && word[b] != KW_CHARS[k][b]) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            kind = KIND_KW_FIRST + KIND_W'(k);
         end
      end
      return kind;
   endfunction

endpackage

/* design/source_char_tokenizer.sv */
// ----------------------------------------------------------------------------
// source_char_tokenizer - streaming lexer, one source byte per transaction
// Skips whitespace and comments, streams identifier/number/string text and
// closes each token with its final kind; end of input flushes and adds eof.
// ----------------------------------------------------------------------------
//
//   channel | direction | tdata            | tuser                          | tlast
//   req     | in        | ch[7:0]          | op (0 char, 1 end of input)    | -
//   rsp     | out       | text[7:0]        | kind, has_text, done, unterm   | last
//
// One request transaction is taken per cycle while the result queue has room
// for two results; its 0, 1 or 2 results enter the queue in the same cycle.
// The rsp port drains one result per cycle, so a run of two-result items
// moves at one result per cycle; a result appears on rsp in the cycle after
// its request at the earliest. Synchronous reset empties the queue and
// returns the lexer to normal mode. rsp stalls back up into req_tready only.

module source_char_tokenizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] ch
   input  logic       req_tuser,    // [0] op
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] text
   output logic [8:0] rsp_tuser,    // [5:0] kind, [6] has_text, [7] token_done,
                                    // [8] unterminated
   output logic       rsp_tlast
);

   localparam logic [5:0] PAIR_NONE = sct_pkg::KIND_EOF;

   typedef enum logic [3:0] {
      MODE_NORMAL,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_DQ,
      MODE_DQ_ESC,
      MODE_SQ,
      MODE_LINE,
      MODE_BLOCK,
      MODE_BLOCK_STAR,
      MODE_HOLD
   } mode_type;

   // lexer state
   mode_type                     mode_ff, mode_in;
   logic [7:0]                   held_ff, held_in;
   logic [2:0]                   len_ff, len_in;
   logic [5:0][7:0]              word_ff;

   // result queue
   sct_pkg::rsp_type             queue_ff [4];
   logic [1:0]                   wr_ptr_ff, rd_ptr_ff;
   logic [2:0]                   count_ff;

   logic                         accept, pop;
   logic [7:0]                   ch;
   logic                         op;

   sct_pkg::rsp_type             res_a, res_b;
   logic [1:0]                   n_res;
   logic                         wb_we;
   logic [2:0]                   wb_addr;

   // what a character does when it starts fresh in normal mode
   mode_type                     sc_mode;
   logic                         sc_emit, sc_hold, sc_word;
   sct_pkg::rsp_type             sc_res;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || c == 8'h0C || c == 8'h0A || c == 8'h0D || c == 8'h09 || c == 8'h0B;
   endfunction

   function automatic logic [5:0] single_kind(input logic [7:0] h);
      logic [5:0] k;
      case (h)
         "=":     k = sct_pkg::KIND_ASSIGN;
         "+":     k = sct_pkg::KIND_PLUS;
         "-":     k = sct_pkg::KIND_MINUS;
         "*":     k = sct_pkg::KIND_STAR;
         "/":     k = sct_pkg::KIND_SLASH;
         "<":     k = sct_pkg::KIND_LT;
         ">":     k = sct_pkg::KIND_GT;
         "!":     k = sct_pkg::KIND_NOT;
         default: k = sct_pkg::KIND_UNKNOWN;
      endcase
      return k;
   endfunction

   function automatic logic [5:0] pair_kind(input logic [7:0] h, input logic [7:0] c);
      logic [5:0] k;
      k = PAIR_NONE;
      if (c == "=") begin
         case (h)
            "=":     k = sct_pkg::KIND_EQ;
            "+":     k = sct_pkg::KIND_PLUS_EQ;
            "-":     k = sct_pkg::KIND_MINUS_EQ;
            "*":     k = sct_pkg::KIND_STAR_EQ;
            "<":     k = sct_pkg::KIND_LE;
            ">":     k = sct_pkg::KIND_GE;
            "!":     k = sct_pkg::KIND_NE;
            default: k = PAIR_NONE;
         endcase
      end
      if (h == "+" && c == "+") k = sct_pkg::KIND_INC;
      if (h == "-" && c == "-") k = sct_pkg::KIND_DEC;
      if (h == "&" && c == "&") k = sct_pkg::KIND_AND;
      if (h == "|" && c == "|") k = sct_pkg::KIND_OR;
      return k;
   endfunction

   assign ch     = req_tdata;
   assign op     = req_tuser;
   assign accept = req_tvalid && req_tready;
   assign pop    = rsp_tvalid && rsp_tready;

   always_comb begin
      sc_mode = MODE_NORMAL;
      sc_emit = 1'b0;
      sc_hold = 1'b0;
      sc_word = 1'b0;
      sc_res  = sct_pkg::make_rsp(sct_pkg::KIND_UNKNOWN, 1'b0, 8'h00, 1'b1, 1'b0);
      if (is_space(ch)) begin
         sc_mode = MODE_NORMAL;
      end else if (ch == "#") begin
         sc_mode = MODE_LINE;
      end else if (ch == "\"") begin
         sc_mode = MODE_DQ;
      end else if (ch == "'") begin
         sc_mode = MODE_SQ;
      end else if (is_alpha(ch)) begin
         sc_mode = MODE_IDENT;
         sc_word = 1'b1;
         sc_emit = 1'b1;
         sc_res  = sct_pkg::make_rsp(sct_pkg::KIND_IDENT, 1'b1, ch, 1'b0, 1'b0);
      end else if (is_digit(ch)) begin
         sc_mode = MODE_NUMBER;
         sc_emit = 1'b1;
         sc_res  = sct_pkg::make_rsp(sct_pkg::KIND_NUMBER, 1'b1, ch, 1'b0, 1'b0);
      end else begin
         case (ch) inside
            ".", "/", "=", "+", "-", "*", "<", ">", "!", "&", "|": begin
               sc_mode = MODE_HOLD;
               sc_hold = 1'b1;
            end
            "(": begin
               sc_emit = 1'b1;
               sc_res.kind = sct_pkg::KIND_LPAREN;
            end
            ")": begin
               sc_emit = 1'b1;
               sc_res.kind = sct_pkg::KIND_RPAREN;
            end
            "{": begin
               sc_emit = 1'b1;
               sc_res.kind = sct_pkg::KIND_LBRACE;
            end
            "}": begin
               sc_emit = 1'b1;
               sc_res.kind = sct_pkg::KIND_RBRACE;
            end
            ":": begin
               sc_emit = 1'b1;
               sc_res.kind = sct_pkg::KIND_COLON;
            end
            ";": begin
               sc_emit = 1'b1;
               sc_res.kind = sct_pkg::KIND_SEMI;
            end
            ",": begin
               sc_emit = 1'b1;
               sc_res.kind = sct_pkg::KIND_COMMA;
            end
            "%": begin
               sc_emit = 1'b1;
               sc_res.kind = sct_pkg::KIND_PERCENT;
            end
            default: begin
               sc_emit = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      logic do_start;
      logic [5:0] pk;
      logic [7:0] esc;
      do_start = 1'b0;
      pk       = pair_kind(held_ff, ch);
      esc      = (ch == "n") ? 8'h0A : ((ch == "t") ? 8'h09 : ch);
      mode_in  = mode_ff;
      held_in  = held_ff;
      len_in   = len_ff;
      wb_we    = 1'b0;
      wb_addr  = len_ff;
      res_a    = '0;
      res_b    = '0;
      n_res    = 2'd0;
      if (op == sct_pkg::OP_END) begin
         unique case (mode_ff) inside
            MODE_IDENT: begin
               res_a = sct_pkg::make_rsp(sct_pkg::keyword_kind(word_ff, len_ff),
                                         1'b0, 8'h00, 1'b1, 1'b0);
               n_res = 2'd1;
            end
            MODE_NUMBER: begin
               res_a = sct_pkg::make_rsp(sct_pkg::KIND_NUMBER, 1'b0, 8'h00, 1'b1, 1'b0);
               n_res = 2'd1;
            end
            MODE_DQ, MODE_DQ_ESC, MODE_SQ: begin
               res_a = sct_pkg::make_rsp(sct_pkg::KIND_STRING, 1'b0, 8'h00, 1'b1, 1'b1);
               n_res = 2'd1;
            end
            MODE_HOLD: begin
               res_a = sct_pkg::make_rsp(single_kind(held_ff), 1'b0, 8'h00, 1'b1, 1'b0);
               n_res = 2'd1;
            end
            default: begin
            end
         endcase
         if (n_res == 2'd1) begin
            res_b = sct_pkg::make_rsp(sct_pkg::KIND_EOF, 1'b0, 8'h00, 1'b1, 1'b0);
         end else begin
            res_a = sct_pkg::make_rsp(sct_pkg::KIND_EOF, 1'b0, 8'h00, 1'b1, 1'b0);
         end
         n_res   = n_res + 2'd1;
         mode_in = MODE_NORMAL;
      end else begin
         unique case (mode_ff) inside
            MODE_IDENT: begin
               if (is_alpha(ch) || is_digit(ch)) begin
                  if (len_ff < 3'(sct_pkg::WORD_DEPTH)) begin
                     wb_we  = 1'b1;
                     len_in = len_ff + 3'd1;
                  end else begin
                     len_in = 3'd7;
                  end
                  res_a = sct_pkg::make_rsp(sct_pkg::KIND_IDENT, 1'b1, ch, 1'b0, 1'b0);
                  n_res = 2'd1;
               end else begin
                  res_a = sct_pkg::make_rsp(sct_pkg::keyword_kind(word_ff, len_ff),
                                            1'b0, 8'h00, 1'b1, 1'b0);
                  n_res = 2'd1;
                  do_start = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (is_digit(ch) || ch == ".") begin
                  res_a = sct_pkg::make_rsp(sct_pkg::KIND_NUMBER, 1'b1, ch, 1'b0, 1'b0);
               end else begin
                  res_a = sct_pkg::make_rsp(sct_pkg::KIND_NUMBER, 1'b0, 8'h00, 1'b1, 1'b0);
                  do_start = 1'b1;
               end
               n_res = 2'd1;
            end
            MODE_DQ: begin
               if (ch == "\"") begin
                  res_a   = sct_pkg::make_rsp(sct_pkg::KIND_STRING, 1'b0, 8'h00, 1'b1, 1'b0);
                  n_res   = 2'd1;
                  mode_in = MODE_NORMAL;
               end else if (ch == "\\") begin
                  mode_in = MODE_DQ_ESC;
               end else begin
                  res_a = sct_pkg::make_rsp(sct_pkg::KIND_STRING, 1'b1, ch, 1'b0, 1'b0);
                  n_res = 2'd1;
               end
            end
            MODE_DQ_ESC: begin
               res_a   = sct_pkg::make_rsp(sct_pkg::KIND_STRING, 1'b1, esc, 1'b0, 1'b0);
               n_res   = 2'd1;
               mode_in = MODE_DQ;
            end
            MODE_SQ: begin
               if (ch == "'") begin
                  res_a   = sct_pkg::make_rsp(sct_pkg::KIND_STRING, 1'b0, 8'h00, 1'b1, 1'b0);
                  mode_in = MODE_NORMAL;
               end else begin
                  res_a = sct_pkg::make_rsp(sct_pkg::KIND_STRING, 1'b1, ch, 1'b0, 1'b0);
               end
               n_res = 2'd1;
            end
            MODE_LINE: begin
               if (ch == 8'h0A) mode_in = MODE_NORMAL;
            end
            MODE_BLOCK: begin
               if (ch == "*") mode_in = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR: begin
               if (ch == "/") begin
                  mode_in = MODE_NORMAL;
               end else if (ch != "*") begin
                  mode_in = MODE_BLOCK;
               end
            end
            MODE_HOLD: begin
               if (held_ff == "/" && ch == "/") begin
                  mode_in = MODE_LINE;
               end else if (held_ff == "/" && ch == "*") begin
                  mode_in = MODE_BLOCK;
               end else if (held_ff == "." && is_digit(ch)) begin
                  // leading dot of a number: both characters go out now
                  res_a   = sct_pkg::make_rsp(sct_pkg::KIND_NUMBER, 1'b1, ".", 1'b0, 1'b0);
                  res_b   = sct_pkg::make_rsp(sct_pkg::KIND_NUMBER, 1'b1, ch, 1'b0, 1'b0);
                  n_res   = 2'd2;
                  mode_in = MODE_NUMBER;
               end else if (held_ff != "/" && held_ff != "." && pk != PAIR_NONE) begin
                  res_a   = sct_pkg::make_rsp(pk, 1'b0, 8'h00, 1'b1, 1'b0);
                  n_res   = 2'd1;
                  mode_in = MODE_NORMAL;
               end else begin
                  res_a = sct_pkg::make_rsp(single_kind(held_ff), 1'b0, 8'h00, 1'b1, 1'b0);
                  n_res = 2'd1;
                  do_start = 1'b1;
               end
            end
            default: begin
               do_start = 1'b1;
            end
         endcase
         if (do_start) begin
            mode_in = sc_mode;
            if (sc_hold) held_in = ch;
            if (sc_word) begin
               wb_we   = 1'b1;
               wb_addr = 3'd0;
               len_in  = 3'd1;
            end
            if (sc_emit) begin
               if (n_res == 2'd0) begin
                  res_a = sc_res;
               end else begin
                  res_b = sc_res;
               end
               n_res = n_res + 2'd1;
            end
         end
      end
      if (n_res == 2'd1) res_a.last = 1'b1;
      if (n_res == 2'd2) res_b.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NORMAL;
         held_ff   <= 8'h00;
         len_ff    <= 3'd0;
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         if (accept) begin
            mode_ff   <= mode_in;
            held_ff   <= held_in;
            len_ff    <= len_in;
            wr_ptr_ff <= wr_ptr_ff + n_res;
         end
         if (pop) rd_ptr_ff <= rd_ptr_ff + 2'd1;
         count_ff <= count_ff + (accept ? {1'b0, n_res} : 3'd0) - {2'b00, pop};
      end
      if (accept && wb_we) word_ff[wb_addr] <= ch;
      if (accept && n_res != 2'd0) queue_ff[wr_ptr_ff] <= res_a;
      if (accept && n_res == 2'd2) queue_ff[wr_ptr_ff + 2'd1] <= res_b;
   end

   assign req_tready = (count_ff <= 3'd2);
   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_tdata  = queue_ff[rd_ptr_ff].text;
   assign rsp_tuser  = {queue_ff[rd_ptr_ff].unterminated, queue_ff[rd_ptr_ff].token_done,
                        queue_ff[rd_ptr_ff].has_text, queue_ff[rd_ptr_ff].kind};
   assign rsp_tlast  = queue_ff[rd_ptr_ff].last;

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("result queue overflow");

   a_end_flushes: assert property (@(posedge clock) disable iff (reset)
      accept && op == sct_pkg::OP_END |=> mode_ff == MODE_NORMAL && count_ff != 3'd0)
      else $error("end of input left mode open or produced no eof");

   a_ident_has_word: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_IDENT |-> len_ff != 3'd0)
      else $error("identifier mode with empty word");

   a_hold_operator: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_HOLD |-> held_ff == "." || held_ff == "/" || held_ff == "=" ||
         held_ff == "+" || held_ff == "-" || held_ff == "*" || held_ff == "<" ||
         held_ff == ">" || held_ff == "!" || held_ff == "&" || held_ff == "|")
      else $error("held character is not an operator");
`endif

endmodule
